FILE: rtl/mbc_pkg.sv
// Shared types, constants and helpers of the maze backtracker carver.
`default_nettype none

package mbc_pkg;

   // configuration port
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0]     GRID_RESET      = 6'd32;

   // default storage size
   localparam int DEF_MAX_X = 32;
   localparam int DEF_MAX_Y = 32;

   // grid dimension arithmetic (holds sizes up to 256 plus a small offset)
   localparam int DIM_W = 9;
   localparam int MIN_DIM = 3;

   // word fields
   localparam int COORD_OUT_W = 5;
   localparam int DIR_W       = 2;

   // visited cell counter
   localparam int COUNT_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   // request kinds
   localparam logic REQ_RESTART = 1'b0;
   localparam logic REQ_TRY     = 1'b1;

   // directions
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DECIDE,
      ST_REPLY
   } mbc_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic try_start;
      logic probe_step;
      logic move_back;
      logic carve;
      logic load_rsp;
   } mbc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic probe_done;
      logic finished;
      logic dead_end;
      logic at_start;
      logic dir_open;
      logic rsp_free;
   } mbc_stat_type;

   // saturate a size register into MIN_DIM..maxv
   function automatic logic [DIM_W-1:0] eff_size(input logic [CSR_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] ext;
      ext = DIM_W'(v);
      if (ext < DIM_W'(MIN_DIM)) begin
         return DIM_W'(MIN_DIM);
      end else if (ext > maxv) begin
         return maxv;
      end else begin
         return ext;
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mbc_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
`default_nettype none

interface mbc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [mbc_pkg::DIR_W-1:0] direction;

   modport source (output valid, output req_type, output direction, input ready);
   modport sink   (input valid, input req_type, input direction, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbc_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`default_nettype none

interface mbc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            carved;
   logic [mbc_pkg::COORD_OUT_W-1:0] wall_x;
   logic [mbc_pkg::COORD_OUT_W-1:0] wall_y;
   logic                            wall_kind;
   logic [mbc_pkg::COORD_OUT_W-1:0] pos_x;
   logic [mbc_pkg::COORD_OUT_W-1:0] pos_y;
   logic                            finished;

   modport source (output valid, output carved, output wall_x, output wall_y,
                   output wall_kind, output pos_x, output pos_y, output finished,
                   input ready);
   modport sink   (input valid, input carved, input wall_x, input wall_y,
                   input wall_kind, input pos_x, input pos_y, input finished,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/mbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mbc_ram #(
   parameter  int WIDTH = 1,
   parameter  int DEPTH = 2,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/mbc_ctrl.sv
// Controller state machine of the maze carver: sequences clear, probe, decide, reply.
`default_nettype none

module mbc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_type,
   output logic                       req_ready,
   input  wire mbc_pkg::mbc_stat_type stat,
   output mbc_pkg::mbc_cmd_type       cmd
);

   mbc_pkg::mbc_state_type state_ff, state_in;
   logic                   restart_ff, restart_in;

   // state register; reset starts with a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mbc_pkg::ST_CLEAR;
         restart_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         restart_ff <= restart_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      restart_in = restart_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         mbc_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               restart_in = 1'b0;
               state_in   = restart_ff ? mbc_pkg::ST_REPLY : mbc_pkg::ST_IDLE;
            end
         end
         mbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == mbc_pkg::REQ_RESTART) begin
                  cmd.clear_start = 1'b1;
                  restart_in      = 1'b1;
                  state_in        = mbc_pkg::ST_CLEAR;
               end else begin
                  cmd.try_start = 1'b1;
                  state_in      = mbc_pkg::ST_PROBE;
               end
            end
         end
         mbc_pkg::ST_PROBE: begin
            cmd.probe_step = 1'b1;
            if (stat.probe_done) begin
               state_in = mbc_pkg::ST_DECIDE;
            end
         end
         mbc_pkg::ST_DECIDE: begin
            if (stat.finished) begin
               state_in = mbc_pkg::ST_REPLY;
            end else if (stat.dead_end && !stat.at_start) begin
               // walk back one parent link and look again
               cmd.move_back = 1'b1;
               state_in      = mbc_pkg::ST_PROBE;
            end else begin
               cmd.carve = stat.dir_open;
               state_in  = mbc_pkg::ST_REPLY;
            end
         end
         mbc_pkg::ST_REPLY: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = mbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mbc_datapath.sv
// Datapath of the maze carver: config, position, counters, grid memories, result register.
`default_nettype none

module mbc_datapath #(
   parameter int MAX_X = mbc_pkg::DEF_MAX_X,
   parameter int MAX_Y = mbc_pkg::DEF_MAX_Y
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [mbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mbc_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic [mbc_pkg::DIR_W-1:0]         req_direction,
   input  wire mbc_pkg::mbc_cmd_type              cmd,
   output mbc_pkg::mbc_stat_type                  stat,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic                                   rsp_carved,
   output logic [mbc_pkg::COORD_OUT_W-1:0]        rsp_wall_x,
   output logic [mbc_pkg::COORD_OUT_W-1:0]        rsp_wall_y,
   output logic                                   rsp_wall_kind,
   output logic [mbc_pkg::COORD_OUT_W-1:0]        rsp_pos_x,
   output logic [mbc_pkg::COORD_OUT_W-1:0]        rsp_pos_y,
   output logic                                   rsp_finished
);

   localparam int XW         = $clog2(MAX_X);
   localparam int YW         = $clog2(MAX_Y);
   localparam int AW         = XW + YW;
   localparam int CELL_DEPTH = 1 << AW;
   localparam int DIM_W      = mbc_pkg::DIM_W;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int PC_W       = 3;
   localparam int NB_N       = 4;

   // configuration registers
   logic [mbc_pkg::CSR_W-1:0] grid_width_ff, grid_height_ff;
   // grid size latched at restart
   logic [DIM_W-1:0]          lat_w_ff, lat_w_in, lat_h_ff, lat_h_in;
   logic [DIM_W-1:0]          eff_w, eff_h;
   logic [PROD_W-1:0]         target_ff;
   // walker state
   logic [XW-1:0]             cur_x_ff, cur_x_in;
   logic [YW-1:0]             cur_y_ff, cur_y_in;
   logic [mbc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;
   // probe state
   logic [PC_W-1:0]           pc_ff, pc_in;
   logic [NB_N-1:0]           open_ff, open_in;
   logic [mbc_pkg::DIR_W-1:0] dir_ff, dir_in;
   // result of the current item
   logic                      carved_ff, carved_in;
   logic [XW-1:0]             wall_x_ff, wall_x_in;
   logic [YW-1:0]             wall_y_ff, wall_y_in;
   logic                      wall_kind_ff, wall_kind_in;
   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_carved_ff, rsp_wall_kind_ff, rsp_finished_ff;
   logic [mbc_pkg::COORD_OUT_W-1:0] rsp_wall_x_ff, rsp_wall_y_ff;
   logic [mbc_pkg::COORD_OUT_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff;

   // neighbors of the current cell
   logic [XW-1:0]             nb_x [NB_N];
   logic [YW-1:0]             nb_y [NB_N];
   logic [NB_N-1:0]           nb_ok;
   logic [1:0]                pc_idx, cap_idx;
   logic [XW-1:0]             sel_x;
   logic [YW-1:0]             sel_y;

   // memory ports
   logic                      vis_we, vis_re, vis_rdata;
   logic [AW-1:0]             vis_waddr, vis_raddr;
   logic                      par_re;
   logic [AW-1:0]             par_addr;
   logic [AW-1:0]             par_raddr;
   logic [AW-1:0]             par_rdata;

   // output coordinate extension
   logic [DIM_W-1:0]          ext_wall_x, ext_wall_y, ext_pos_x, ext_pos_y;
   logic                      finished_now;

   assign eff_w = mbc_pkg::eff_size(grid_width_ff, DIM_W'(MAX_X));
   assign eff_h = mbc_pkg::eff_size(grid_height_ff, DIM_W'(MAX_Y));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= mbc_pkg::GRID_RESET;
         grid_height_ff <= mbc_pkg::GRID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mbc_pkg::REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            mbc_pkg::REG_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // interior cell count goal, from the live size registers
   always_ff @(posedge clock) begin
      target_ff <= PROD_W'(eff_w - DIM_W'(2)) * PROD_W'(eff_h - DIM_W'(2));
   end

   assign finished_now = PROD_W'(count_ff) >= target_ff;

   // neighbor coordinates and whether each lies inside the interior and off the start cell
   always_comb begin
      nb_x[mbc_pkg::DIR_UP]    = cur_x_ff;
      nb_y[mbc_pkg::DIR_UP]    = cur_y_ff - YW'(1);
      nb_x[mbc_pkg::DIR_DOWN]  = cur_x_ff;
      nb_y[mbc_pkg::DIR_DOWN]  = cur_y_ff + YW'(1);
      nb_x[mbc_pkg::DIR_LEFT]  = cur_x_ff - XW'(1);
      nb_y[mbc_pkg::DIR_LEFT]  = cur_y_ff;
      nb_x[mbc_pkg::DIR_RIGHT] = cur_x_ff + XW'(1);
      nb_y[mbc_pkg::DIR_RIGHT] = cur_y_ff;
      for (int k = 0; k < NB_N; k++) begin
         nb_ok[k] = (nb_x[k] != '0) && (nb_y[k] != '0) &&
                    (DIM_W'(nb_x[k]) + DIM_W'(2) <= lat_w_ff) &&
                    (DIM_W'(nb_y[k]) + DIM_W'(2) <= lat_h_ff) &&
                    !(nb_x[k] == XW'(1) && nb_y[k] == YW'(1));
      end
   end

   assign pc_idx  = pc_ff[1:0];
   assign cap_idx = pc_idx - 2'd1;
   assign sel_x   = nb_x[dir_ff];
   assign sel_y   = nb_y[dir_ff];

   // visited memory: clearing sweep or carve writes, neighbor probe reads
   assign vis_we    = cmd.clear_step | cmd.carve;
   assign vis_waddr = cmd.clear_step ? clr_addr_ff : {sel_x, sel_y};
   assign vis_re    = cmd.probe_step && !pc_ff[2];
   assign vis_raddr = {nb_x[pc_idx], nb_y[pc_idx]};

   // parent memory: written on carve, read once at probe start
   assign par_re    = cmd.probe_step && (pc_ff == '0);
   assign par_addr  = {sel_x, sel_y};
   assign par_raddr = {cur_x_ff, cur_y_ff};

   mbc_ram #(
      .WIDTH (1),
      .DEPTH (CELL_DEPTH)
   ) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (cmd.carve),
      .re    (vis_re),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   mbc_ram #(
      .WIDTH (AW),
      .DEPTH (CELL_DEPTH)
   ) u_parent (
      .clock (clock),
      .we    (cmd.carve),
      .waddr (par_addr),
      .wdata ({cur_x_ff, cur_y_ff}),
      .re    (par_re),
      .raddr (par_raddr),
      .rdata (par_rdata)
   );

   // walker, probe and result next values
   always_comb begin
      lat_w_in     = lat_w_ff;
      lat_h_in     = lat_h_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      pc_in        = pc_ff;
      open_in      = open_ff;
      dir_in       = dir_ff;
      carved_in    = carved_ff;
      wall_x_in    = wall_x_ff;
      wall_y_in    = wall_y_ff;
      wall_kind_in = wall_kind_ff;

      if (cmd.clear_start) begin
         lat_w_in     = eff_w;
         lat_h_in     = eff_h;
         cur_x_in     = XW'(1);
         cur_y_in     = YW'(1);
         count_in     = mbc_pkg::COUNT_W'(1);
         clr_addr_in  = '0;
         carved_in    = 1'b0;
         wall_x_in    = '0;
         wall_y_in    = '0;
         wall_kind_in = 1'b0;
      end

      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      if (cmd.try_start) begin
         dir_in       = req_direction;
         pc_in        = '0;
         carved_in    = 1'b0;
         wall_x_in    = '0;
         wall_y_in    = '0;
         wall_kind_in = 1'b0;
      end

      // one neighbor read issued per step, captured a step later
      if (cmd.probe_step) begin
         if (!pc_ff[2]) begin
            pc_in = pc_ff + PC_W'(1);
         end
         if (pc_ff != '0) begin
            open_in[cap_idx] = nb_ok[cap_idx] && !vis_rdata;
         end
      end

      if (cmd.move_back) begin
         cur_x_in = par_rdata[AW-1:YW];
         cur_y_in = par_rdata[YW-1:0];
         pc_in    = '0;
      end

      if (cmd.carve) begin
         carved_in    = 1'b1;
         wall_kind_in = (dir_ff == mbc_pkg::DIR_LEFT) || (dir_ff == mbc_pkg::DIR_RIGHT);
         if ((dir_ff == mbc_pkg::DIR_UP) || (dir_ff == mbc_pkg::DIR_LEFT)) begin
            wall_x_in = cur_x_ff;
            wall_y_in = cur_y_ff;
         end else begin
            wall_x_in = sel_x;
            wall_y_in = sel_y;
         end
         cur_x_in = sel_x;
         cur_y_in = sel_y;
         if (count_ff != mbc_pkg::COUNT_MAX) begin
            count_in = count_ff + mbc_pkg::COUNT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_w_ff    <= mbc_pkg::eff_size(mbc_pkg::GRID_RESET, DIM_W'(MAX_X));
         lat_h_ff    <= mbc_pkg::eff_size(mbc_pkg::GRID_RESET, DIM_W'(MAX_Y));
         cur_x_ff    <= XW'(1);
         cur_y_ff    <= YW'(1);
         count_ff    <= mbc_pkg::COUNT_W'(1);
         clr_addr_ff <= '0;
      end else begin
         lat_w_ff    <= lat_w_in;
         lat_h_ff    <= lat_h_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         count_ff    <= count_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pc_ff        <= pc_in;
      open_ff      <= open_in;
      dir_ff       <= dir_in;
      carved_ff    <= carved_in;
      wall_x_ff    <= wall_x_in;
      wall_y_ff    <= wall_y_in;
      wall_kind_ff <= wall_kind_in;
   end

   // response word register
   assign ext_wall_x = DIM_W'(wall_x_ff);
   assign ext_wall_y = DIM_W'(wall_y_ff);
   assign ext_pos_x  = DIM_W'(cur_x_ff);
   assign ext_pos_y  = DIM_W'(cur_y_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_carved_ff    <= carved_ff;
         rsp_wall_x_ff    <= ext_wall_x[mbc_pkg::COORD_OUT_W-1:0];
         rsp_wall_y_ff    <= ext_wall_y[mbc_pkg::COORD_OUT_W-1:0];
         rsp_wall_kind_ff <= wall_kind_ff;
         rsp_pos_x_ff     <= ext_pos_x[mbc_pkg::COORD_OUT_W-1:0];
         rsp_pos_y_ff     <= ext_pos_y[mbc_pkg::COORD_OUT_W-1:0];
         rsp_finished_ff  <= finished_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_carved    = rsp_carved_ff;
   assign rsp_wall_x    = rsp_wall_x_ff;
   assign rsp_wall_y    = rsp_wall_y_ff;
   assign rsp_wall_kind = rsp_wall_kind_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;
   assign rsp_finished  = rsp_finished_ff;

   // status to the controller
   always_comb begin
      stat            = '0;
      stat.clear_done = (clr_addr_ff == '1);
      stat.probe_done = pc_ff[2];
      stat.finished   = finished_now;
      stat.dead_end   = (open_ff == '0);
      stat.at_start   = (cur_x_ff == XW'(1)) && (cur_y_ff == YW'(1));
      stat.dir_open   = open_ff[dir_ff];
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

`ifndef NO_ASSERTIONS
   // walker never leaves the interior of the latched grid
   a_cur_interior: assert property (@(posedge clock) disable iff (reset)
      (cur_x_ff != '0) && (cur_y_ff != '0) &&
      (DIM_W'(cur_x_ff) + DIM_W'(2) <= lat_w_ff) &&
      (DIM_W'(cur_y_ff) + DIM_W'(2) <= lat_h_ff))
      else $error("walker outside grid interior");

   // start cell always counts
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0)
      else $error("visited count dropped to zero");

   // each carve below saturation adds exactly one cell
   a_carve_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.carve && (count_ff != mbc_pkg::COUNT_MAX) |=>
      count_ff == $past(count_ff) + mbc_pkg::COUNT_W'(1))
      else $error("carve did not advance visited count");

   // a backtrack step always changes the position
   a_back_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.move_back |=>
      (cur_x_ff != $past(cur_x_ff)) || (cur_y_ff != $past(cur_y_ff)))
      else $error("backtrack step stayed in place");
`endif

endmodule

`default_nettype wire

FILE: rtl/maze_backtracker_carver_unit.sv
// Top level of the randomized depth-first maze carver.
`default_nettype none

// Randomized depth-first maze carver. A restart word (req_type 0) latches the
// grid size from csr registers 0 (width) and 1 (height), both saturated into
// 3..MAX_X / 3..MAX_Y, and clears the visited memory with a sweep over all
// 2^(clog2(MAX_X)+clog2(MAX_Y)) addresses (1024 at the default size); its
// reply follows the end of the sweep. The same sweep runs after reset, and
// no request is taken until it ends. A try word (req_type 1) reads the four
// neighbors of the current cell one per cycle through the single read port of
// the visited memory, then passes a decide state and a reply state. Every
// backtrack step along the parent links adds one parent read overlapped with
// a fresh four-neighbor probe. One request is in flight at a time; a new one
// is taken while the previous reply still waits on the response port. Each
// request yields exactly one reply word. Removed walls are reported in the
// reply stream only; wall state is kept by the consumer.
module maze_backtracker_carver_unit #(
   parameter int MAX_X = mbc_pkg::DEF_MAX_X,
   parameter int MAX_Y = mbc_pkg::DEF_MAX_Y
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mbc_req_if.sink                            req_if,
   mbc_rsp_if.source                          rsp_if,
   input  wire logic                          csr_we,
   input  wire logic [mbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mbc_pkg::CSR_W-1:0]     csr_wdata
);

   mbc_pkg::mbc_cmd_type  cmd;
   mbc_pkg::mbc_stat_type stat;
   logic                  req_ready;

   // sequencing
   mbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_if.ready = req_ready;

   // grid storage and arithmetic
   mbc_datapath #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_direction (req_if.direction),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_carved    (rsp_if.carved),
      .rsp_wall_x    (rsp_if.wall_x),
      .rsp_wall_y    (rsp_if.wall_y),
      .rsp_wall_kind (rsp_if.wall_kind),
      .rsp_pos_x     (rsp_if.pos_x),
      .rsp_pos_y     (rsp_if.pos_y),
      .rsp_finished  (rsp_if.finished)
   );

endmodule

`default_nettype wire

FILE: bench/maze_backtracker_carver_unit_tb.sv
// Self-checking testbench for the maze carver: directed table, random phases, live predictor.
`timescale 1ns / 100ps

module maze_backtracker_carver_unit_tb;

   localparam int GRID_X         = mbc_pkg::DEF_MAX_X;
   localparam int GRID_Y         = mbc_pkg::DEF_MAX_Y;
   localparam int COORD_OUT_W    = mbc_pkg::COORD_OUT_W;
   localparam int DIR_W          = mbc_pkg::DIR_W;
   localparam int CSR_W          = mbc_pkg::CSR_W;
   localparam int CSR_IDX_W      = mbc_pkg::CSR_IDX_W;
   localparam int RANDOM_WORDS   = 1600;
   localparam int MISMATCH_SHOWN = 10;
   localparam int TAIL_CYCLES    = 40;
   localparam int PHASE_CAP      = 300;

   // one reply word, in port order
   typedef struct packed {
      logic                   carved;
      logic [COORD_OUT_W-1:0] wall_x;
      logic [COORD_OUT_W-1:0] wall_y;
      logic                   wall_kind;
      logic [COORD_OUT_W-1:0] pos_x;
      logic [COORD_OUT_W-1:0] pos_y;
      logic                   finished;
   } carve_word_type;

   typedef enum logic {ROW_CFG, ROW_WORD} row_kind_type;

   // directed row: a size register write or a request word
   typedef struct {
      row_kind_type   kind;
      int             sel;    // csr index, or req_type
      int             val;    // csr data, or direction
      bit             typed;  // want holds a hand-written reply
      carve_word_type want;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   mbc_req_if req_ch();
   mbc_rsp_if rsp_ch();

   maze_backtracker_carver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Maze predictor. Walls are not kept: no reply field depends on them.
   // ---------------------------------------------------------------
   bit                     maze_seen [GRID_X][GRID_Y];
   logic [COORD_OUT_W-1:0] link_x    [GRID_X][GRID_Y];
   logic [COORD_OUT_W-1:0] link_y    [GRID_X][GRID_Y];
   int                     at_x, at_y;
   int                     visit_tally;
   logic [CSR_W-1:0]       cols_reg, rows_reg;

   carve_word_type expected_words[$];
   plan_row_type   plan[$];
   int  words_sent, restarts_sent, cfg_writes, carves_seen, done_seen, mismatches;
   bit  calm;   // no gaps, no stalls in this phase

   function automatic int clamp_dim(logic [CSR_W-1:0] v, int top);
      int d;
      d = int'(v);
      if (d < mbc_pkg::MIN_DIM) return mbc_pkg::MIN_DIM;
      if (d > top) return top;
      return d;
   endfunction

   // outside the storage counts as taken
   function automatic bit cell_open(int x, int y);
      if (x < 0 || y < 0 || x >= GRID_X || y >= GRID_Y) return 1'b0;
      return !maze_seen[x][y];
   endfunction

   function automatic bit boxed_in(int x, int y);
      return !cell_open(x, y - 1) && !cell_open(x, y + 1) &&
             !cell_open(x - 1, y) && !cell_open(x + 1, y);
   endfunction

   // finished test reads the live size registers
   function automatic bit maze_done();
      int w, h;
      w = clamp_dim(cols_reg, GRID_X);
      h = clamp_dim(rows_reg, GRID_Y);
      return visit_tally >= (w - 2) * (h - 2);
   endfunction

   function automatic void maze_clear();
      int w, h;
      w = clamp_dim(cols_reg, GRID_X);
      h = clamp_dim(rows_reg, GRID_Y);
      for (int x = 0; x < GRID_X; x++) begin
         for (int y = 0; y < GRID_Y; y++) begin
            if (x >= w || y >= h) begin
               maze_seen[x][y] = 1'b1;
            end else begin
               maze_seen[x][y] = (x == 0 || x == w - 1 || y == 0 || y == h - 1);
            end
         end
      end
      at_x = 1;
      at_y = 1;
      maze_seen[1][1] = 1'b1;
      visit_tally = 1;
   endfunction

   function automatic carve_word_type maze_step(logic rt, logic [DIR_W-1:0] dir);
      carve_word_type w;
      int x, y, nx, ny, hops;
      w = '0;
      if (rt == mbc_pkg::REQ_RESTART) begin
         maze_clear();
      end else if (!maze_done()) begin
         x = at_x;
         y = at_y;
         hops = 0;
         // walk back along parent links out of dead ends
         while (boxed_in(x, y) && !(x == 1 && y == 1) && hops < GRID_X * GRID_Y) begin
            nx = int'(link_x[x][y]);
            ny = int'(link_y[x][y]);
            x = nx;
            y = ny;
            hops++;
         end
         nx = x;
         ny = y;
         case (dir)
            mbc_pkg::DIR_UP:   ny = y - 1;
            mbc_pkg::DIR_DOWN: ny = y + 1;
            mbc_pkg::DIR_LEFT: nx = x - 1;
            default:           nx = x + 1;
         endcase
         if (cell_open(nx, ny)) begin
            w.carved    = 1'b1;
            w.wall_kind = (dir == mbc_pkg::DIR_LEFT || dir == mbc_pkg::DIR_RIGHT);
            // up/left moves open a wall of the current cell, else of the neighbor
            if (dir == mbc_pkg::DIR_UP || dir == mbc_pkg::DIR_LEFT) begin
               w.wall_x = COORD_OUT_W'(x);
               w.wall_y = COORD_OUT_W'(y);
            end else begin
               w.wall_x = COORD_OUT_W'(nx);
               w.wall_y = COORD_OUT_W'(ny);
            end
            link_x[nx][ny]    = COORD_OUT_W'(x);
            link_y[nx][ny]    = COORD_OUT_W'(y);
            maze_seen[nx][ny] = 1'b1;
            if (visit_tally < int'(mbc_pkg::COUNT_MAX)) visit_tally++;
            x = nx;
            y = ny;
         end
         at_x = x;
         at_y = y;
      end
      w.pos_x    = COORD_OUT_W'(at_x);
      w.pos_y    = COORD_OUT_W'(at_y);
      w.finished = maze_done();
      return w;
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic send_word(logic rt, logic [DIR_W-1:0] dir, bit typed,
                            carve_word_type want);
      int             gap;
      carve_word_type predicted;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= rt;
      req_ch.direction <= dir;
      do @(posedge clock); while (!req_ch.ready);
      predicted = maze_step(rt, dir);
      if (typed) predicted = want;
      expected_words = {expected_words, predicted};
      words_sent++;
      if (rt == mbc_pkg::REQ_RESTART) restarts_sent++;
   endtask

   // drop valid and drain every outstanding reply
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // one write cycle with the enable then dropped, so writes never share a time step
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mbc_pkg::REG_GRID_WIDTH) cols_reg = data;
      else rows_reg = data;
      cfg_writes++;
      @(posedge clock);
   endtask

   function automatic carve_word_type word_of(bit c, int wx, int wy, bit k, int px, int py,
                                              bit f);
      return {c, COORD_OUT_W'(wx), COORD_OUT_W'(wy), k, COORD_OUT_W'(px), COORD_OUT_W'(py), f};
   endfunction

   function automatic plan_row_type cfg_row(int idx, int val);
      return '{ROW_CFG, idx, val, 1'b0, '0};
   endfunction

   function automatic plan_row_type word_row(int rt, int dir, bit typed = 1'b0,
                                             carve_word_type want = '0);
      return '{ROW_WORD, rt, dir, typed, want};
   endfunction

   function automatic void add_row(plan_row_type r);
      plan = {plan, r};
   endfunction

   function automatic string describe(carve_word_type w);
      return $sformatf("carved=%0d wall=(%0d,%0d) kind=%0d pos=(%0d,%0d) finished=%0d",
                       w.carved, w.wall_x, w.wall_y, w.wall_kind, w.pos_x, w.pos_y,
                       w.finished);
   endfunction

   // ---------------------------------------------------------------
   // Reply side: random stalls, compare against the oldest expectation
   // ---------------------------------------------------------------
   initial begin : reply_side
      carve_word_type got, want;
      int             stall;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = {rsp_ch.carved, rsp_ch.wall_x, rsp_ch.wall_y, rsp_ch.wall_kind,
                rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.finished};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("[%0t] reply word with none expected: %s", $realtime, describe(got));
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN) begin
                  $display("[%0t] reply mismatch", $realtime);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
            if (got.carved === 1'b1) carves_seen++;
            if (got.finished === 1'b1) done_seen++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      int               budget, pick, n, cells;
      logic [CSR_W-1:0] wv, hv;
      bit               live;

      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= mbc_pkg::REQ_TRY;
      req_ch.direction <= mbc_pkg::DIR_UP;
      csr_we           <= 1'b0;
      csr_index        <= mbc_pkg::REG_GRID_WIDTH;
      csr_wdata        <= '0;
      calm        = 1'b0;
      words_sent  = 0;
      restarts_sent = 0;
      cfg_writes  = 0;
      carves_seen = 0;
      done_seen   = 0;
      mismatches  = 0;
      budget      = 0;
      cols_reg    = mbc_pkg::GRID_RESET;
      rows_reg    = mbc_pkg::GRID_RESET;
      maze_clear();

      // directed table, starting from the reset grid (32 x 32)
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_UP, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_LEFT, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_DOWN));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_RIGHT));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_UP));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_LEFT));
      // shrink to the minimum without restart: maze counts as finished, try is inert
      add_row(cfg_row(mbc_pkg::REG_GRID_WIDTH, 3));
      add_row(cfg_row(mbc_pkg::REG_GRID_HEIGHT, 3));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_DOWN, 1'b1,
                       word_of(0, 0, 0, 0, 2, 1, 1)));
      add_row(word_row(mbc_pkg::REQ_RESTART, mbc_pkg::DIR_UP, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 1)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_RIGHT, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 1)));
      // sizes below range saturate up to 3
      add_row(cfg_row(mbc_pkg::REG_GRID_WIDTH, 0));
      add_row(cfg_row(mbc_pkg::REG_GRID_HEIGHT, 2));
      add_row(word_row(mbc_pkg::REQ_RESTART, mbc_pkg::DIR_DOWN, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 1)));
      // sizes above range saturate down to the storage size
      add_row(cfg_row(mbc_pkg::REG_GRID_WIDTH, 63));
      add_row(cfg_row(mbc_pkg::REG_GRID_HEIGHT, 63));
      add_row(word_row(mbc_pkg::REQ_RESTART, mbc_pkg::DIR_LEFT, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      // two-cell maze
      add_row(cfg_row(mbc_pkg::REG_GRID_WIDTH, 4));
      add_row(cfg_row(mbc_pkg::REG_GRID_HEIGHT, 3));
      add_row(word_row(mbc_pkg::REQ_RESTART, mbc_pkg::DIR_RIGHT, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_UP, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_RIGHT, 1'b1,
                       word_of(1, 2, 1, 1, 2, 1, 1)));
      // grow without restart: dead end walks back to the start cell, nothing carved
      add_row(cfg_row(mbc_pkg::REG_GRID_HEIGHT, 4));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_LEFT, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      // 3 x 2 interior: dead end at (1,2), backtrack then carve onward
      add_row(cfg_row(mbc_pkg::REG_GRID_WIDTH, 5));
      add_row(word_row(mbc_pkg::REQ_RESTART, mbc_pkg::DIR_UP, 1'b1,
                       word_of(0, 0, 0, 0, 1, 1, 0)));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_RIGHT));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_DOWN));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_LEFT));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_RIGHT));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_UP));
      add_row(word_row(mbc_pkg::REQ_TRY, mbc_pkg::DIR_DOWN, 1'b1,
                       word_of(0, 0, 0, 0, 3, 1, 1)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            wait_idle();
            csr_write(CSR_IDX_W'(plan[i].sel), CSR_W'(plan[i].val));
         end else begin
            send_word(plan[i].sel[0], DIR_W'(plan[i].val), plan[i].typed, plan[i].want);
         end
      end

      // random phases: new size, usually a restart, then a run of random tries
      while (budget < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            wv = CSR_W'($urandom_range(3, 12));
            hv = CSR_W'($urandom_range(3, 12));
         end else if (pick < 80) begin
            wv = CSR_W'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(33, 63));
            hv = CSR_W'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(33, 63));
         end else begin
            wv = CSR_W'($urandom_range(3, 32));
            hv = CSR_W'($urandom_range(3, 32));
         end
         live = ($urandom_range(0, 9) == 0);
         calm = ($urandom_range(0, 3) == 0);
         wait_idle();
         if ($urandom_range(0, 1)) begin
            csr_write(mbc_pkg::REG_GRID_WIDTH, wv);
            csr_write(mbc_pkg::REG_GRID_HEIGHT, hv);
         end else begin
            csr_write(mbc_pkg::REG_GRID_HEIGHT, hv);
            csr_write(mbc_pkg::REG_GRID_WIDTH, wv);
         end
         if (!live) begin
            send_word(mbc_pkg::REQ_RESTART, DIR_W'($urandom_range(0, 3)), 1'b0, '0);
            budget++;
         end
         cells = (clamp_dim(wv, GRID_X) - 2) * (clamp_dim(hv, GRID_Y) - 2);
         n = cells * 4 + 8;
         if (n > PHASE_CAP) n = PHASE_CAP;
         if (n > RANDOM_WORDS - budget) n = RANDOM_WORDS - budget;
         repeat (n) begin
            // a stray restart now and then breaks a walk in progress
            if ($urandom_range(0, 99) == 0)
               send_word(mbc_pkg::REQ_RESTART, DIR_W'($urandom_range(0, 3)), 1'b0, '0);
            else
               send_word(mbc_pkg::REQ_TRY, DIR_W'($urandom_range(0, 3)), 1'b0, '0);
            budget++;
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d restarts) across %0d size register writes.",
               words_sent, restarts_sent, cfg_writes);
      $display("Replies: %0d carved a wall, %0d flagged a finished maze; %0d mismatches.",
               carves_seen, done_seen, mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASS maze_backtracker_carver_unit");
      end else begin
         $display("FAIL maze_backtracker_carver_unit");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(10_000_000);
      $display("Timeout with %0d replies outstanding.", expected_words.size());
      $display("FAIL maze_backtracker_carver_unit");
      $finish;
   end

endmodule

FILE: sim.f
rtl/mbc_pkg.sv
rtl/mbc_req_if.sv
rtl/mbc_rsp_if.sv
rtl/mbc_ram.sv
rtl/mbc_ctrl.sv
rtl/mbc_datapath.sv
rtl/maze_backtracker_carver_unit.sv
bench/maze_backtracker_carver_unit_tb.sv
